[hdl/lpdd_pkg.sv]
// Package for the light pulse duration detector: sizes, codes and the
// structs passed between its modules. No dependencies.
package lpdd_pkg;

   localparam int MAX_EVENTS   = 64;
   localparam int SAMPLE_WIDTH = 12;
   localparam int COUNT_W      = $clog2(MAX_EVENTS + 1);

   localparam int SAMPLE_W    = 12;
   localparam int TIME_W      = 32;
   localparam int THRESHOLD_W = 12;
   localparam int TIMEOUT_W   = 16;
   localparam int OUT_COUNT_W = 7;
   localparam int CSR_ADDR_W  = 1;
   localparam int CSR_DATA_W  = 16;

   localparam logic [SAMPLE_W-1:0] SAMPLE_MASK = SAMPLE_W'((1 << SAMPLE_WIDTH) - 1);

   localparam logic [THRESHOLD_W-1:0] THRESHOLD_RESET = '0;
   localparam logic [TIMEOUT_W-1:0]   TIMEOUT_RESET   = TIMEOUT_W'(3000);

   typedef enum logic [CSR_ADDR_W-1:0] {
      REG_LIGHT_THRESHOLD = 1'b0,
      REG_IDLE_TIMEOUT    = 1'b1
   } reg_index_type;

   typedef enum logic [1:0] {
      KIND_PAUSE_END = 2'd0,
      KIND_FLASH_END = 2'd1,
      KIND_SEQ_TIMEOUT = 2'd2,
      KIND_SEQ_FULL    = 2'd3
   } event_kind_type;

   typedef struct packed {
      logic [THRESHOLD_W-1:0] light_threshold;
      logic [TIMEOUT_W-1:0]   idle_timeout_ms;
   } cfg_type;

   typedef struct packed {
      logic               is_idle;
      logic               edge_seen;
      logic [TIME_W-1:0]  edge_time;
      logic [TIME_W-1:0]  last_edge_stamp;
      logic [COUNT_W-1:0] entry_total;
   } state_type;

   typedef struct packed {
      logic                   valid;
      event_kind_type         kind;
      logic [TIME_W-1:0]      span_ms;
      logic [OUT_COUNT_W-1:0] recorded_count;
   } result_type;

endpackage

[hdl/light_pulse_duration_detector_unit.sv]
// Light pulse duration detector, top level.
// Uses lpdd_pkg, lpdd_csr and lpdd_step.
//
// Each req beat carries one sensor sample and its millisecond timestamp.
// A sample below the light threshold is light, above it is dark. The block
// emits a rsp beat when a pause or a flash ends, and when a sequence ends by
// idle timeout (if anything was recorded) or because the entry table is full.
// Many samples produce no rsp beat at all.
// The csr port writes the threshold and the idle timeout; write it only while
// no beat is in flight.
// A sample is taken into an input register, evaluated by one level of compare
// and subtract logic, and its result lands in the output register. One beat
// is taken every cycle while rsp does not stall.
// While rsp waits on rsp_tready, the input register still takes one more
// beat; further req beats then stall until the result is taken. Samples that
// produce no result keep moving only while the output register is free.
// A synchronous reset empties both registers, restores the register reset
// values and starts a fresh sequence.
module light_pulse_duration_detector_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [lpdd_pkg::CSR_ADDR_W-1:0] csr_index,
   input  logic [lpdd_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // Fields from bit 0: sample [11:0], now_ms [43:12], zero fill [47:44].
   input  logic [47:0]                     req_tdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // Fields from bit 0: span_ms [31:0], recorded_count [38:32], zero fill [39].
   output logic [39:0]                     rsp_tdata,
   // Fields from bit 0: event_kind [1:0].
   output logic [1:0]                      rsp_tuser
);

   lpdd_pkg::cfg_type    cfg;
   lpdd_pkg::state_type  st_ff;
   lpdd_pkg::state_type  st_in;
   lpdd_pkg::result_type res;

   logic                          in_valid_ff;
   logic                          in_valid_in;
   logic [lpdd_pkg::SAMPLE_W-1:0] in_sample_ff;
   logic [lpdd_pkg::TIME_W-1:0]   in_now_ff;
   logic                          rsp_valid_ff;
   logic                          rsp_valid_in;
   logic [1:0]                    rsp_kind_ff;
   logic [lpdd_pkg::TIME_W-1:0]   rsp_span_ff;
   logic [lpdd_pkg::OUT_COUNT_W-1:0] rsp_count_ff;
   logic                          advance;
   logic                          req_take;

   lpdd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   lpdd_step u_step (
      .cfg     (cfg),
      .st      (st_ff),
      .sample  (in_sample_ff),
      .now_ms  (in_now_ff),
      .st_next (st_in),
      .res     (res)
   );

   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = res.valid;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff           <= 1'b0;
         rsp_valid_ff          <= 1'b0;
         st_ff.is_idle         <= 1'b1;
         st_ff.edge_seen       <= 1'b0;
         st_ff.edge_time       <= '0;
         st_ff.last_edge_stamp <= '0;
         st_ff.entry_total     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            st_ff <= st_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_sample_ff <= req_tdata[lpdd_pkg::SAMPLE_W-1:0];
         in_now_ff    <= req_tdata[lpdd_pkg::SAMPLE_W +: lpdd_pkg::TIME_W];
      end
      if (advance && res.valid) begin
         rsp_kind_ff  <= res.kind;
         rsp_span_ff  <= res.span_ms;
         rsp_count_ff <= res.recorded_count;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_count_ff, rsp_span_ff};
   assign rsp_tuser  = rsp_kind_ff;

endmodule

[hdl/lpdd_csr.sv]
// Configuration registers of the light pulse duration detector.
// Depends on lpdd_pkg.
module lpdd_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [lpdd_pkg::CSR_ADDR_W-1:0] csr_index,
   input  logic [lpdd_pkg::CSR_DATA_W-1:0] csr_wdata,
   output lpdd_pkg::cfg_type               cfg
);

   lpdd_pkg::cfg_type cfg_ff;
   lpdd_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (lpdd_pkg::reg_index_type'(csr_index))
            lpdd_pkg::REG_LIGHT_THRESHOLD:
               cfg_in.light_threshold = csr_wdata[lpdd_pkg::THRESHOLD_W-1:0];
            lpdd_pkg::REG_IDLE_TIMEOUT:
               cfg_in.idle_timeout_ms = csr_wdata[lpdd_pkg::TIMEOUT_W-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.light_threshold <= lpdd_pkg::THRESHOLD_RESET;
         cfg_ff.idle_timeout_ms <= lpdd_pkg::TIMEOUT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

[hdl/lpdd_step.sv]
// Per-sample decision logic: edge detection, span, sequence end.
// Purely combinational; depends on lpdd_pkg.
module lpdd_step (
   input  lpdd_pkg::cfg_type                 cfg,
   input  lpdd_pkg::state_type               st,
   input  logic [lpdd_pkg::SAMPLE_W-1:0]     sample,
   input  logic [lpdd_pkg::TIME_W-1:0]       now_ms,
   output lpdd_pkg::state_type               st_next,
   output lpdd_pkg::result_type              res
);

   logic [lpdd_pkg::SAMPLE_W-1:0]  sample_m;
   logic                           is_light;
   logic                           is_dark;
   logic                           full;
   logic [lpdd_pkg::TIME_W-1:0]    span;
   logic [lpdd_pkg::TIME_W-1:0]    idle_time;
   logic [lpdd_pkg::COUNT_W-1:0]   count_inc;

   assign sample_m  = sample & lpdd_pkg::SAMPLE_MASK;
   assign is_light  = sample_m < cfg.light_threshold;
   assign is_dark   = sample_m > cfg.light_threshold;
   assign full      = st.entry_total >= lpdd_pkg::COUNT_W'(lpdd_pkg::MAX_EVENTS);
   assign span      = now_ms - st.edge_time;
   assign idle_time = now_ms - st.last_edge_stamp;
   assign count_inc = st.entry_total + lpdd_pkg::COUNT_W'(1);

   always_comb begin
      st_next            = st;
      res.valid          = 1'b0;
      res.kind           = lpdd_pkg::KIND_PAUSE_END;
      res.span_ms        = span;
      res.recorded_count = lpdd_pkg::OUT_COUNT_W'(count_inc);
      if (full) begin
         res.valid                = 1'b1;
         res.kind                 = lpdd_pkg::KIND_SEQ_FULL;
         res.span_ms              = '0;
         res.recorded_count       = lpdd_pkg::OUT_COUNT_W'(st.entry_total);
         st_next.entry_total      = '0;
         st_next.is_idle          = 1'b1;
         st_next.edge_seen        = 1'b0;
         st_next.edge_time        = '0;
         st_next.last_edge_stamp  = now_ms;
      end else if (st.is_idle && is_light) begin
         res.valid               = st.edge_seen;
         res.kind                = lpdd_pkg::KIND_PAUSE_END;
         if (st.edge_seen) begin
            st_next.entry_total = count_inc;
         end
         st_next.edge_time       = now_ms;
         st_next.edge_seen       = 1'b1;
         st_next.is_idle         = 1'b0;
         st_next.last_edge_stamp = now_ms;
      end else if (!st.is_idle && is_dark) begin
         res.valid               = 1'b1;
         res.kind                = lpdd_pkg::KIND_FLASH_END;
         st_next.entry_total     = count_inc;
         st_next.edge_time       = now_ms;
         st_next.edge_seen       = 1'b1;
         st_next.is_idle         = 1'b1;
         st_next.last_edge_stamp = now_ms;
      end else if (st.is_idle &&
                   idle_time > lpdd_pkg::TIME_W'(cfg.idle_timeout_ms)) begin
         // A flash that just ended leaves zero idle time, so only a quiet
         // idle sample can reach the timeout.
         res.valid               = st.entry_total != '0;
         res.kind                = lpdd_pkg::KIND_SEQ_TIMEOUT;
         res.span_ms             = '0;
         res.recorded_count      = lpdd_pkg::OUT_COUNT_W'(st.entry_total);
         st_next.entry_total     = '0;
         st_next.is_idle         = 1'b1;
         st_next.edge_seen       = 1'b0;
         st_next.edge_time       = '0;
         st_next.last_edge_stamp = now_ms;
      end
   end

endmodule

[hdl/lpdd_checker.sv]
// Port-level checks for the light pulse duration detector, bound to the top.
// Depends on lpdd_pkg and light_pulse_duration_detector_unit.
module lpdd_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata,
   input logic [1:0]  rsp_tuser
);

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("rsp_tvalid high after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled rsp beat changed");

   a_end_span_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == lpdd_pkg::KIND_SEQ_TIMEOUT ||
                     rsp_tuser == lpdd_pkg::KIND_SEQ_FULL) |-> rsp_tdata[31:0] == '0)
      else $error("sequence end beat carries a span");

   a_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[38:32] != '0)
      else $error("result beat with zero recorded count");

endmodule

bind light_pulse_duration_detector_unit lpdd_checker u_lpdd_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

[test/lpdd_checker.sv]
// Checker for the light pulse duration detector: tracks the csr writes, predicts
// the rsp beat, if any, caused by each accepted req beat and compares them in order.
// Depends on lpdd_pkg only.
module lpdd_scoreboard
   import lpdd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [47:0]           req_tdata,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [39:0]           rsp_tdata,
   input  logic [1:0]            rsp_tuser,
   output int                    fail_count,
   output int                    pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      event_kind_type         kind;
      logic [TIME_W-1:0]      span;
      logic [OUT_COUNT_W-1:0] count;
   } pulse_report_type;

   pulse_report_type report_q[$];
   pulse_report_type want;
   pulse_report_type made;

   logic [THRESHOLD_W-1:0] thr_cfg;
   logic [TIMEOUT_W-1:0]   tmo_cfg;
   logic                   dark;
   logic                   had_edge;
   logic [TIME_W-1:0]      edge_at;
   logic [TIME_W-1:0]      last_edge_at;
   int                     entries;

   initial begin
      fail_count = 0;
      pending    = 0;
   end

   function automatic void restart_seq(input logic [TIME_W-1:0] now);
      entries      = 0;
      dark         = 1'b1;
      had_edge     = 1'b0;
      edge_at      = '0;
      last_edge_at = now;
   endfunction

   function automatic bit measure_sample(input logic [SAMPLE_W-1:0] smp,
                                         input logic [TIME_W-1:0] now,
                                         output pulse_report_type rpt);
      bit hit;
      int total;
      hit = 1'b0;
      rpt = '{KIND_PAUSE_END, '0, '0};
      if (entries >= MAX_EVENTS) begin
         rpt = '{KIND_SEQ_FULL, '0, OUT_COUNT_W'(entries)};
         restart_seq(now);
         return 1'b1;
      end
      if (dark && smp < thr_cfg) begin
         if (had_edge) begin
            entries++;
            rpt = '{KIND_PAUSE_END, now - edge_at, OUT_COUNT_W'(entries)};
            hit = 1'b1;
         end
         edge_at      = now;
         had_edge     = 1'b1;
         dark         = 1'b0;
         last_edge_at = now;
      end else if (!dark && smp > thr_cfg) begin
         entries++;
         rpt = '{KIND_FLASH_END, now - edge_at, OUT_COUNT_W'(entries)};
         hit          = 1'b1;
         edge_at      = now;
         had_edge     = 1'b1;
         dark         = 1'b1;
         last_edge_at = now;
      end
      if (dark && (now - last_edge_at) > tmo_cfg) begin
         total = entries;
         restart_seq(now);
         if (total != 0) begin
            rpt = '{KIND_SEQ_TIMEOUT, '0, OUT_COUNT_W'(total)};
            hit = 1'b1;
         end
      end
      return hit;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         thr_cfg = THRESHOLD_RESET;
         tmo_cfg = TIMEOUT_RESET;
         restart_seq('0);
         report_q.delete();
      end else begin
         if (csr_we) begin
            case (reg_index_type'(csr_index))
               REG_LIGHT_THRESHOLD: thr_cfg = csr_wdata[THRESHOLD_W-1:0];
               REG_IDLE_TIMEOUT:    tmo_cfg = csr_wdata[TIMEOUT_W-1:0];
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            if (report_q.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("%0t: unexpected rsp beat kind %0d span %0d count %0d",
                           $realtime, rsp_tuser, rsp_tdata[31:0], rsp_tdata[38:32]);
            end else begin
               want = report_q.pop_front();
               if (want.kind !== rsp_tuser || want.span !== rsp_tdata[31:0] ||
                   want.count !== rsp_tdata[38:32]) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display({"%0t: rsp mismatch, expected kind %0d span %0d count %0d,",
                               " got %0d %0d %0d"},
                              $realtime, want.kind, want.span, want.count,
                              rsp_tuser, rsp_tdata[31:0], rsp_tdata[38:32]);
               end
            end
         end
         if (req_tvalid && req_tready) begin
            if (measure_sample(req_tdata[11:0], req_tdata[43:12], made))
               report_q.push_back(made);
         end
      end
      pending = report_q.size();
   end

endmodule

[test/testbench.sv]
// Top of the light pulse duration detector test: clock, reset, csr writes and
// sample beats with random gaps and rsp stalls. Needs lpdd_pkg, the block
// light_pulse_duration_detector_unit and lpdd_scoreboard.
module testbench;
   import lpdd_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_we = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_index = REG_LIGHT_THRESHOLD;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [47:0]           req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [39:0]           rsp_tdata;
   logic [1:0]            rsp_tuser;
   int                    fail_count;
   int                    pending;

   logic [THRESHOLD_W-1:0] thr = THRESHOLD_RESET;
   logic [TIMEOUT_W-1:0]   tmo = TIMEOUT_RESET;
   logic [TIME_W-1:0]      stamp_ms = '0;
   bit                     calm = 1'b0;
   int                     beats_sent = 0;

   light_pulse_duration_detector_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   lpdd_scoreboard pulse_check (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .fail_count (fail_count),
      .pending    (pending)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic push_sample(input logic [SAMPLE_W-1:0] smp, input logic [TIME_W-1:0] now);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 7);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {4'b0, now, smp};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
      beats_sent++;
   endtask

   task automatic quiesce();
      req_tvalid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (6) @(negedge clock);
   endtask

   task automatic set_reg(input reg_index_type idx, input logic [CSR_DATA_W-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   task automatic configure(input logic [THRESHOLD_W-1:0] t, input logic [TIMEOUT_W-1:0] m);
      quiesce();
      set_reg(REG_LIGHT_THRESHOLD, CSR_DATA_W'(t));
      set_reg(REG_IDLE_TIMEOUT, m);
      thr = t;
      tmo = m;
   endtask

   function automatic logic [SAMPLE_W-1:0] bright();
      return (thr == 0) ? thr : SAMPLE_W'($urandom_range(0, int'(thr) - 1));
   endfunction

   function automatic logic [SAMPLE_W-1:0] dim();
      return (thr == 4095) ? thr : SAMPLE_W'($urandom_range(int'(thr) + 1, 4095));
   endfunction

   function automatic logic [TIME_W-1:0] flash_advance();
      int r;
      r = $urandom_range(0, 15);
      if (r == 0)
         return $urandom;
      else if (r < 4)
         return $urandom_range(0, 100000);
      return $urandom_range(0, 3000);
   endfunction

   // Dark stretches stay inside the idle timeout so that the sequence keeps going.
   task automatic trace_sequence(input int edges);
      int reps;
      for (int e = 0; e < edges; e++) begin
         if (e % 2 == 0) begin
            stamp_ms += $urandom_range(0, tmo / 4);
            push_sample(bright(), stamp_ms);
            reps = $urandom_range(0, 2);
            repeat (reps) begin
               stamp_ms += flash_advance();
               push_sample(($urandom_range(0, 3) == 0) ? thr : bright(), stamp_ms);
            end
         end else begin
            stamp_ms += flash_advance();
            push_sample(dim(), stamp_ms);
            reps = $urandom_range(0, 2);
            repeat (reps) begin
               stamp_ms += $urandom_range(0, tmo / 4);
               push_sample(($urandom_range(0, 3) == 0) ? thr : dim(), stamp_ms);
            end
         end
      end
      if (edges % 2 == 1) begin
         stamp_ms += flash_advance();
         push_sample(dim(), stamp_ms);
      end
      if ($urandom_range(0, 3) != 0) begin
         stamp_ms += TIME_W'(tmo) + 1 + $urandom_range(0, 40);
         push_sample(($urandom_range(0, 1) == 0) ? thr : dim(), stamp_ms);
      end
   endtask

   task automatic noise_burst(input int n);
      repeat (n) begin
         if ($urandom_range(0, 3) == 0)
            stamp_ms = $urandom;
         else
            stamp_ms += $urandom_range(0, 2 * int'(tmo) + 2);
         push_sample(SAMPLE_W'($urandom), stamp_ms);
      end
   endtask

   initial begin
      logic [THRESHOLD_W-1:0] thr_list[9];
      logic [TIMEOUT_W-1:0]   tmo_list[9];
      int                     quota[9];
      int                     target;
      int                     pick;

      thr_list = '{12'd2000, 12'd1, 12'd4094, 12'd0, 12'd4095, 12'd2048, 12'd300, 12'd0,
                   12'd3500};
      tmo_list = '{16'd3000, 16'd0, 16'd65535, 16'd100, 16'd5, 16'd1, 16'd500, 16'd0,
                   16'd65534};
      quota    = '{190, 190, 190, 30, 30, 190, 190, 190, 190};
      thr_list[7] = THRESHOLD_W'($urandom_range(1, 4094));
      tmo_list[7] = TIMEOUT_W'($urandom_range(0, 65535));

      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // With the reset threshold nothing is light; an idle gap with no entries ends silently.
      push_sample(12'd0, 32'd0);
      push_sample(12'd4095, 32'hFFFF_FFFF);

      configure(12'd2000, 16'd3000);
      push_sample(12'd4095, 32'd100);
      push_sample(12'd0, 32'd200);
      push_sample(12'd2000, 32'd300);
      push_sample(12'd4095, 32'd1300);
      push_sample(12'd1999, 32'd1500);
      push_sample(12'd2001, 32'd2000);
      push_sample(12'd2000, 32'd6000);
      push_sample(12'd2001, 32'd9500);
      // A flash span across the timestamp wrap, followed by a pause and a flash.
      push_sample(12'd0, 32'hFFFF_FF00);
      push_sample(12'd4095, 32'h0000_0100);
      push_sample(12'd0, 32'h0000_0200);
      push_sample(12'd4095, 32'h0000_0300);
      // The idle time must exceed the timeout, equality is not enough.
      push_sample(12'd4095, 32'h0000_0300 + 32'd3000);
      push_sample(12'd4095, 32'h0000_0300 + 32'd3001);

      for (int p = 0; p < 9; p++) begin
         configure(thr_list[p], tmo_list[p]);
         calm = (p % 3 == 1);
         stamp_ms = (p % 2 == 0) ? $urandom : 32'hFFFF_0000 + $urandom_range(0, 65535);
         target = beats_sent + quota[p];
         if (p == 0 || p == 2 || p == 6)
            trace_sequence($urandom_range(66, 72));
         while (beats_sent < target) begin
            pick = $urandom_range(0, 9);
            if (pick < 7)
               trace_sequence(($urandom_range(0, 9) == 0) ? $urandom_range(60, 70)
                                                          : $urandom_range(1, 12));
            else if (pick < 9)
               noise_burst($urandom_range(1, 5));
            else
               quiesce();
         end
      end

      req_tvalid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (10) @(negedge clock);
      if (fail_count == 0 && pending == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

   initial begin
      int stall;
      while (reset) @(negedge clock);
      forever begin
         stall = calm ? 0 : $urandom_range(0, 7);
         if (stall != 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         @(negedge clock);
      end
   end

   initial begin
      #10_000_000;
      $display("Some tests failed");
      $finish;
   end

endmodule

[files.f]
hdl/lpdd_pkg.sv
hdl/lpdd_csr.sv
hdl/lpdd_step.sv
hdl/light_pulse_duration_detector_unit.sv
hdl/lpdd_checker.sv
test/lpdd_checker.sv
test/testbench.sv
